[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[src/rpc_pkg.sv]
// ----------------------------------------------------------------------------
// rpc_pkg
// types and constants of the relative path checker
// ----------------------------------------------------------------------------
package rpc_pkg;

   typedef enum logic [3:0] {
      VERDICT_OK        = 4'd0,
      VERDICT_EMPTY     = 4'd1,
      VERDICT_ABSOLUTE  = 4'd2,
      VERDICT_CONTROL   = 4'd3,
      VERDICT_BACKSLASH = 4'd4,
      VERDICT_COLON     = 4'd5,
      VERDICT_TRAILING  = 4'd6,
      VERDICT_EMPTYCOMP = 4'd7,
      VERDICT_DOTCOMP   = 4'd8,
      VERDICT_DOTPKG    = 4'd9
   } verdict_type;

   typedef enum logic [2:0] {
      SHAPE_EMPTY = 3'd0,
      SHAPE_DOT   = 3'd1,
      SHAPE_DDOT  = 3'd2,
      SHAPE_DP    = 3'd3,
      SHAPE_DPK   = 3'd4,
      SHAPE_DPKG  = 3'd5,
      SHAPE_OTHER = 3'd6
   } shape_type;

   localparam logic [7:0] CHAR_SLASH     = 8'h2F;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;
   localparam logic [7:0] CHAR_P         = 8'h70;
   localparam logic [7:0] CHAR_K         = 8'h6B;
   localparam logic [7:0] CHAR_G         = 8'h67;
   localparam logic [7:0] CTRL_LIMIT     = 8'h20;
   localparam logic [7:0] CHAR_DEL       = 8'h7F;

   localparam logic [2:0] COMP_LEN_MAX   = 3'd7;

endpackage

[src/rpc_req_if.sv]
// ----------------------------------------------------------------------------
// rpc_req_if
// request channel: one path byte or an end marker per request
// ----------------------------------------------------------------------------
interface rpc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_byte;
   logic       end_marker;

   modport source (output valid, output path_byte, output end_marker, input ready);
   modport sink   (input valid, input path_byte, input end_marker, output ready);
endinterface

[src/rpc_rsp_if.sv]
// ----------------------------------------------------------------------------
// rpc_rsp_if
// response channel: one verdict per checked path
// ----------------------------------------------------------------------------
interface rpc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink   (input valid, input verdict, output ready);
endinterface

[src/relative_path_checker_unit.sv]
// ----------------------------------------------------------------------------
// relative_path_checker_unit
// streaming checker that gives one verdict per relative file path
// ----------------------------------------------------------------------------
// A path arrives as one request per byte and ends with an end-marker request,
// which carries no byte. One request is taken every cycle; the input stalls
// only while a verdict waits in the output register and the response side is
// not ready, whatever the waiting request carries. The verdict appears, from the
// output register, in the cycle after the end marker is taken, and all
// tracking state is back at its reset value for the next path at that same
// edge.
`include "assert_macros.svh"

module relative_path_checker_unit (
   input  logic        clock,
   input  logic        reset,
   rpc_req_if.sink     req_ch,
   rpc_rsp_if.source   rsp_ch
);

   logic                  seen_any_ff, seen_any_in;
   logic                  starts_abs_ff, starts_abs_in;
   rpc_pkg::verdict_type  char_fault_ff, char_fault_in;
   rpc_pkg::verdict_type  comp_fault_ff, comp_fault_in;
   logic [2:0]            comp_len_ff, comp_len_in;
   rpc_pkg::shape_type    shape_ff, shape_in;
   logic                  in_first_ff, in_first_in;
   logic                  last_slash_ff, last_slash_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rpc_pkg::verdict_type  verdict_ff, verdict_in;

   logic                  accept;
   logic [7:0]            b;
   rpc_pkg::verdict_type  close_fault;
   rpc_pkg::verdict_type  final_verdict;

   function automatic rpc_pkg::verdict_type comp_check(
      input logic [2:0]         len,
      input rpc_pkg::shape_type shape,
      input logic               first
   );
      rpc_pkg::verdict_type v;
      v = rpc_pkg::VERDICT_OK;
      if (len == 3'd0) begin
         v = rpc_pkg::VERDICT_EMPTYCOMP;
      end else if (shape == rpc_pkg::SHAPE_DOT || shape == rpc_pkg::SHAPE_DDOT) begin
         v = rpc_pkg::VERDICT_DOTCOMP;
      end else if (first && shape == rpc_pkg::SHAPE_DPKG) begin
         v = rpc_pkg::VERDICT_DOTPKG;
      end
      return v;
   endfunction

   function automatic rpc_pkg::shape_type next_shape(
      input rpc_pkg::shape_type shape,
      input logic [7:0]         c
   );
      rpc_pkg::shape_type s;
      s = rpc_pkg::SHAPE_OTHER;
      case (shape)
         rpc_pkg::SHAPE_EMPTY: begin
            if (c == rpc_pkg::CHAR_DOT) s = rpc_pkg::SHAPE_DOT;
         end
         rpc_pkg::SHAPE_DOT: begin
            if (c == rpc_pkg::CHAR_DOT) s = rpc_pkg::SHAPE_DDOT;
            else if (c == rpc_pkg::CHAR_P) s = rpc_pkg::SHAPE_DP;
         end
         rpc_pkg::SHAPE_DP: begin
            if (c == rpc_pkg::CHAR_K) s = rpc_pkg::SHAPE_DPK;
         end
         rpc_pkg::SHAPE_DPK: begin
            if (c == rpc_pkg::CHAR_G) s = rpc_pkg::SHAPE_DPKG;
         end
         default: begin
            s = rpc_pkg::SHAPE_OTHER;
         end
      endcase
      return s;
   endfunction

   assign req_ch.ready   = !rsp_valid_ff || rsp_ch.ready;
   assign accept         = req_ch.valid && req_ch.ready;
   assign b              = req_ch.path_byte;
   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.verdict = verdict_ff;

   // fault of the open component, kept only if none was seen earlier
   always_comb begin
      if (comp_fault_ff != rpc_pkg::VERDICT_OK) begin
         close_fault = comp_fault_ff;
      end else begin
         close_fault = comp_check(comp_len_ff, shape_ff, in_first_ff);
      end
   end

   always_comb begin
      if (!seen_any_ff) begin
         final_verdict = rpc_pkg::VERDICT_EMPTY;
      end else if (starts_abs_ff) begin
         final_verdict = rpc_pkg::VERDICT_ABSOLUTE;
      end else if (char_fault_ff != rpc_pkg::VERDICT_OK) begin
         final_verdict = char_fault_ff;
      end else if (last_slash_ff) begin
         final_verdict = rpc_pkg::VERDICT_TRAILING;
      end else begin
         final_verdict = close_fault;
      end
   end

   always_comb begin
      seen_any_in   = seen_any_ff;
      starts_abs_in = starts_abs_ff;
      char_fault_in = char_fault_ff;
      comp_fault_in = comp_fault_ff;
      comp_len_in   = comp_len_ff;
      shape_in      = shape_ff;
      in_first_in   = in_first_ff;
      last_slash_in = last_slash_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      verdict_in    = verdict_ff;

      if (accept && req_ch.end_marker) begin
         rsp_valid_in  = 1'b1;
         verdict_in    = final_verdict;
         seen_any_in   = 1'b0;
         starts_abs_in = 1'b0;
         char_fault_in = rpc_pkg::VERDICT_OK;
         comp_fault_in = rpc_pkg::VERDICT_OK;
         comp_len_in   = 3'd0;
         shape_in      = rpc_pkg::SHAPE_EMPTY;
         in_first_in   = 1'b1;
         last_slash_in = 1'b0;
      end else if (accept) begin
         seen_any_in = 1'b1;
         if (!seen_any_ff && b == rpc_pkg::CHAR_SLASH) begin
            starts_abs_in = 1'b1;
         end
         if (char_fault_ff == rpc_pkg::VERDICT_OK) begin
            if (b < rpc_pkg::CTRL_LIMIT || b == rpc_pkg::CHAR_DEL) begin
               char_fault_in = rpc_pkg::VERDICT_CONTROL;
            end else if (b == rpc_pkg::CHAR_BACKSLASH) begin
               char_fault_in = rpc_pkg::VERDICT_BACKSLASH;
            end else if (b == rpc_pkg::CHAR_COLON) begin
               char_fault_in = rpc_pkg::VERDICT_COLON;
            end
         end
         if (b == rpc_pkg::CHAR_SLASH) begin
            comp_fault_in = close_fault;
            comp_len_in   = 3'd0;
            shape_in      = rpc_pkg::SHAPE_EMPTY;
            in_first_in   = 1'b0;
            last_slash_in = 1'b1;
         end else begin
            if (comp_len_ff != rpc_pkg::COMP_LEN_MAX) begin
               comp_len_in = comp_len_ff + 3'd1;
            end
            shape_in      = next_shape(shape_ff, b);
            last_slash_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_any_ff   <= 1'b0;
         starts_abs_ff <= 1'b0;
         char_fault_ff <= rpc_pkg::VERDICT_OK;
         comp_fault_ff <= rpc_pkg::VERDICT_OK;
         comp_len_ff   <= 3'd0;
         shape_ff      <= rpc_pkg::SHAPE_EMPTY;
         in_first_ff   <= 1'b1;
         last_slash_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         seen_any_ff   <= seen_any_in;
         starts_abs_ff <= starts_abs_in;
         char_fault_ff <= char_fault_in;
         comp_fault_ff <= comp_fault_in;
         comp_len_ff   <= comp_len_in;
         shape_ff      <= shape_in;
         in_first_ff   <= in_first_in;
         last_slash_ff <= last_slash_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      verdict_ff <= verdict_in;
   end

   // assertions
   `ASSERT_CLK(a_rsp_from_end, clock, reset,
      $rose(rsp_valid_ff) |-> $past(accept && req_ch.end_marker))
   `ASSERT_CLK(a_clear_after_end, clock, reset,
      (accept && req_ch.end_marker) |=> (!seen_any_ff && in_first_ff && !last_slash_ff))
   `ASSERT_NEVER(a_abs_without_byte, clock, reset, starts_abs_ff && !seen_any_ff)
   `ASSERT_CLK(a_len_shape_agree, clock, reset,
      (comp_len_ff == 3'd0) == (shape_ff == rpc_pkg::SHAPE_EMPTY))

endmodule
